### src/kgrr_pkg.sv
// ----------------------------------------------------------------------------
// kgrr_pkg
// Shared constants and types for the k-group reverse reorder core.
// ----------------------------------------------------------------------------
`default_nettype none

package kgrr_pkg;

  // Element width and group size register.
  localparam int VALUE_W          = 32;
  localparam int GROUP_SIZE_W     = 5;
  localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RESET = 5'd4;

  // Group buffer depth: default and the largest value supported.
  localparam int MAX_GROUP_DEF    = 16;
  localparam int MAX_GROUP_LIMIT  = 256;

  // Width of a group element count in a descriptor (holds 0..MAX_GROUP_LIMIT).
  localparam int DESC_CNT_W       = $clog2(MAX_GROUP_LIMIT + 1);

  // One closed group, handed from the fill side to the drain side.
  typedef struct packed {
    logic                  seq_end;  // group closes the sequence
    logic                  reverse;  // full group: emit newest first
    logic                  bank;     // buffer bank holding the group
    logic [DESC_CNT_W-1:0] count;    // number of held elements (at least 1)
  } desc_t;

endpackage

`default_nettype wire

### src/kgrr_ram.sv
// ----------------------------------------------------------------------------
// kgrr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kgrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/kgrr_desc_fifo.sv
// ----------------------------------------------------------------------------
// kgrr_desc_fifo
// Two-entry queue of group descriptors between the fill and drain sides.
// ----------------------------------------------------------------------------
`default_nettype none

module kgrr_desc_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire kgrr_pkg::desc_t push_desc,
  input  wire logic           pop,
  output logic                valid,
  output kgrr_pkg::desc_t     head
);
  import kgrr_pkg::*;

  desc_t      slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Descriptor storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_desc;
    end
  end

  assign valid = (count != 2'd0);
  assign head  = slots[rptr];

endmodule

`default_nettype wire

### src/kgrr_front.sv
// ----------------------------------------------------------------------------
// kgrr_front
// Fill side: accepts elements, writes them into the current buffer bank and
// closes a group when it is full or the sequence ends.
// ----------------------------------------------------------------------------
`default_nettype none

module kgrr_front #(
  parameter int MAX_GROUP = kgrr_pkg::MAX_GROUP_DEF,
  localparam int IDX_W    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
  localparam int CNT_W    = $clog2(MAX_GROUP + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic signed [kgrr_pkg::VALUE_W-1:0] s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  input  wire logic [kgrr_pkg::GROUP_SIZE_W-1:0]   group_size,
  output logic                                     wr_en,
  output logic [IDX_W:0]                           wr_addr,
  output logic [kgrr_pkg::VALUE_W-1:0]             wr_data,
  output logic                                     desc_push,
  output kgrr_pkg::desc_t                          desc,
  input  wire logic                                bank_release
);
  import kgrr_pkg::*;

  localparam int CMP_W = (CNT_W > GROUP_SIZE_W) ? CNT_W : GROUP_SIZE_W;

  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_inc;
  logic             wr_bank;
  logic [1:0]       outstanding;
  logic             accept;
  logic             group_full;
  logic             close_group;

  // Input is taken while a bank is free for filling.
  assign s_axis_tready = (outstanding != 2'd2);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Element count including the arriving one.
  assign fill_inc = fill_count + CNT_W'(1);

  // A group is full at the configured size (zero acts as one) or at the
  // buffer depth; a lowered size flushes everything already held.
  assign group_full = (group_size == '0) ||
                      (CMP_W'(fill_inc) >= CMP_W'(group_size)) ||
                      (fill_inc == CNT_W'(MAX_GROUP));
  assign close_group = accept && (group_full || s_axis_tlast);

  // Buffer write.
  assign wr_en   = accept;
  assign wr_addr = {wr_bank, fill_count[IDX_W-1:0]};
  assign wr_data = s_axis_tdata;

  // Descriptor for a closed group.
  assign desc_push     = close_group;
  assign desc.seq_end  = s_axis_tlast;
  assign desc.reverse  = group_full;
  assign desc.bank     = wr_bank;
  assign desc.count    = DESC_CNT_W'(fill_inc);

  // Fill counter, bank toggle and count of banks awaiting drain.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      wr_bank     <= 1'b0;
      outstanding <= 2'd0;
    end else begin
      if (close_group) begin
        fill_count <= '0;
        wr_bank    <= ~wr_bank;
      end else if (accept) begin
        fill_count <= fill_inc;
      end
      outstanding <= outstanding + {1'b0, close_group} - {1'b0, bank_release};
    end
  end

endmodule

`default_nettype wire

### src/kgrr_back.sv
// ----------------------------------------------------------------------------
// kgrr_back
// Drain side: takes a group descriptor, reads its bank in forward or reverse
// order and feeds a two-entry output buffer on the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module kgrr_back #(
  parameter int MAX_GROUP = kgrr_pkg::MAX_GROUP_DEF,
  localparam int IDX_W    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
  localparam int CNT_W    = $clog2(MAX_GROUP + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          desc_valid,
  input  wire kgrr_pkg::desc_t               desc,
  output logic                               desc_pop,
  output logic                               rd_en,
  output logic [IDX_W:0]                     rd_addr,
  input  wire logic [kgrr_pkg::VALUE_W-1:0]  rd_data,
  output logic                               bank_release,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic signed [kgrr_pkg::VALUE_W-1:0] m_axis_tdata,
  output logic                               m_axis_tlast,
  output logic [0:0]                         m_axis_tuser
);
  import kgrr_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               run_last;
    logic               seq_end;
  } out_entry_t;

  logic             active;
  logic             cur_bank;
  logic             cur_reverse;
  logic             cur_seq_end;
  logic [CNT_W-1:0] cur_count;
  logic [CNT_W-1:0] rd_cnt;
  logic [CNT_W-1:0] rev_idx;
  logic             rd_last;

  logic             pend;
  logic             pend_run_last;
  logic             pend_seq_end;

  out_entry_t       obuf [2];
  logic             owptr;
  logic             orptr;
  logic [1:0]       ocount;
  logic             opop;
  logic [1:0]       occ_after;

  // Output buffer handshake.
  assign m_axis_tvalid = (ocount != 2'd0);
  assign opop          = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = obuf[orptr].value;
  assign m_axis_tlast  = obuf[orptr].seq_end;
  assign m_axis_tuser  = obuf[orptr].run_last;

  // A read is issued only when its data is sure to find room in the buffer.
  assign occ_after = ocount + {1'b0, pend} - {1'b0, opop};
  assign rd_en     = active && (occ_after < 2'd2);

  // Read address: newest first for a full group, arrival order otherwise.
  assign rev_idx = cur_count - CNT_W'(1) - rd_cnt;
  assign rd_addr = {cur_bank, cur_reverse ? rev_idx[IDX_W-1:0] : rd_cnt[IDX_W-1:0]};
  assign rd_last = (rd_cnt == cur_count - CNT_W'(1));

  // The bank is free once its last read has been issued.
  assign bank_release = rd_en && rd_last;
  assign desc_pop     = !active && desc_valid;

  // Group sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      rd_cnt <= '0;
      pend   <= 1'b0;
    end else begin
      if (desc_pop) begin
        active <= 1'b1;
        rd_cnt <= '0;
      end else if (rd_en) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
        if (rd_last) begin
          active <= 1'b0;
        end
      end
      pend <= rd_en;
    end
  end

  // Current group and in-flight read flags.
  always_ff @(posedge clk) begin
    if (desc_pop) begin
      cur_bank    <= desc.bank;
      cur_reverse <= desc.reverse;
      cur_seq_end <= desc.seq_end;
      cur_count   <= desc.count[CNT_W-1:0];
    end
    if (rd_en) begin
      pend_run_last <= rd_last;
      pend_seq_end  <= rd_last && cur_seq_end;
    end
  end

  // Output buffer pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      owptr  <= 1'b0;
      orptr  <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (pend) begin
        owptr <= ~owptr;
      end
      if (opop) begin
        orptr <= ~orptr;
      end
      ocount <= occ_after;
    end
  end

  // Output buffer storage.
  always_ff @(posedge clk) begin
    if (pend) begin
      obuf[owptr] <= '{value: rd_data, run_last: pend_run_last, seq_end: pend_seq_end};
    end
  end

endmodule

`default_nettype wire

### src/k_group_reverse_reorder_core.sv
// ----------------------------------------------------------------------------
// k_group_reverse_reorder_core
// Stream reorder that reverses each full group of elements.
// ----------------------------------------------------------------------------
// Elements arrive one per transaction on the s_axis side, with tlast on the
// final element of a sequence. They are gathered into groups of group_size
// (zero acts as one, values above MAX_GROUP act as MAX_GROUP); a full group
// leaves reversed, a partial group closed by tlast leaves in arrival order.
// On m_axis, tuser marks the last result of each group and tlast the final
// result of the sequence. Elements fill one of two buffer banks while the
// other drains. Draining a group first picks up its group descriptor, then
// issues one RAM read per result; input stalls only while both banks wait
// for draining. group_size is written through the cfg channel; the user
// must write it only while the core is idle, the core does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module k_group_reverse_reorder_core #(
  parameter int MAX_GROUP = kgrr_pkg::MAX_GROUP_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write: group_size.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [kgrr_pkg::GROUP_SIZE_W-1:0]   cfg_data,
  // Input stream.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic signed [kgrr_pkg::VALUE_W-1:0] s_axis_tdata,  // [31:0] elem_value
  input  wire logic                                s_axis_tlast,  // seq_end
  // Result stream.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic signed [kgrr_pkg::VALUE_W-1:0]      m_axis_tdata,  // [31:0] out_value
  output logic [0:0]                               m_axis_tuser,  // [0] run_last
  output logic                                     m_axis_tlast   // out_seq_end
);
  import kgrr_pkg::*;

  localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic [GROUP_SIZE_W-1:0] group_size;
  logic                    wr_en;
  logic [IDX_W:0]          wr_addr;
  logic [VALUE_W-1:0]      wr_data;
  logic                    rd_en;
  logic [IDX_W:0]          rd_addr;
  logic [VALUE_W-1:0]      rd_data;
  logic                    desc_push;
  desc_t                   push_desc;
  logic                    desc_pop;
  logic                    desc_valid;
  desc_t                   head_desc;
  logic                    bank_release;

  // Group size register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GROUP_SIZE_RESET;
    end else if (cfg_valid) begin
      group_size <= cfg_data;
    end
  end

  kgrr_front #(
    .MAX_GROUP (MAX_GROUP)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .group_size    (group_size),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .desc_push     (desc_push),
    .desc          (push_desc),
    .bank_release  (bank_release)
  );

  kgrr_desc_fifo u_desc_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_push),
    .push_desc (push_desc),
    .pop       (desc_pop),
    .valid     (desc_valid),
    .head      (head_desc)
  );

  // Two banks of group storage.
  kgrr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (2 * (2 ** IDX_W))
  ) u_group_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kgrr_back #(
    .MAX_GROUP (MAX_GROUP)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .desc_valid    (desc_valid),
    .desc          (head_desc),
    .desc_pop      (desc_pop),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .bank_release  (bank_release),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for k_group_reverse_reorder_core.
// ----------------------------------------------------------------------------
// Streams element sequences through the core under several group sizes,
// including zero and sizes above the buffer depth. Every accepted element
// but the directed pass-through rows goes through a local model of the group
// reversal, and each result transaction is checked field by field against
// the oldest expected result. A short table of directed rows comes first,
// followed by random phases with random idle gaps on both streams, one long
// hold-off of the result side, and size changes while a group is still open.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kgrr_pkg::*;

  localparam int MAX_GROUP      = MAX_GROUP_DEF;
  localparam int RANDOM_ITEMS   = 80;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 4 * MAX_GROUP;
  localparam int LONG_HOLD      = 120;
  localparam int PRINT_LIMIT    = 40;
  localparam int PRESSURE_PHASE = 2;
  localparam int PLAN_LEN       = 32;
  localparam int unsigned PHASE_SIZES [8] = '{1, 16, 3, 0, 31, 2, 5, 17};

  // Directed rows: a register write, an element checked by the model, or an
  // element whose pass-through result is written straight into the expected queue.
  typedef enum logic [1:0] {ROW_CFG, ROW_ELEM, ROW_PASS} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [VALUE_W-1:0] data;
    logic               last;
  } plan_row_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               run_last;
    logic               seq_end;
  } reorder_out_t;

  logic                            clk;
  logic                            rst           = 1'b1;
  logic                            cfg_valid     = 1'b0;
  logic                            cfg_ready;
  logic [GROUP_SIZE_W-1:0]         cfg_data      = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic signed [VALUE_W-1:0]       s_axis_tdata  = '0;   // [31:0] elem_value
  logic                            s_axis_tlast  = 1'b0; // seq_end
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic signed [VALUE_W-1:0]       m_axis_tdata;         // [31:0] out_value
  logic [0:0]                      m_axis_tuser;         // [0] run_last
  logic                            m_axis_tlast;         // out_seq_end

  // Local copy of the group size register and of the open group.
  logic [GROUP_SIZE_W-1:0] group_size_q;
  logic [VALUE_W-1:0]      open_group[$];
  reorder_out_t            expected_out[$];
  int                      err_count   = 0;
  int                      holds_asked = 0;

  plan_row_t plan [PLAN_LEN] = '{
    // Reset size of four: one full group, then a short group closed by the end flag.
    '{ROW_ELEM, 32'h0000_0001, 1'b0},
    '{ROW_ELEM, 32'h0000_0002, 1'b0},
    '{ROW_ELEM, 32'h0000_0003, 1'b0},
    '{ROW_ELEM, 32'h0000_0004, 1'b0},
    '{ROW_ELEM, 32'h7FFF_FFFF, 1'b0},
    '{ROW_ELEM, 32'h8000_0000, 1'b1},
    // Size zero behaves as one: every element passes straight through.
    '{ROW_CFG,  32'd0,         1'b0},
    '{ROW_PASS, 32'hFFFF_FFFF, 1'b0},
    '{ROW_PASS, 32'h0000_0000, 1'b1},
    // Oversized setting saturates to the buffer depth; the end flag lands
    // on a full group.
    '{ROW_CFG,  32'd31,        1'b0},
    '{ROW_ELEM, 32'h0000_A001, 1'b0},
    '{ROW_ELEM, 32'h0000_A002, 1'b0},
    '{ROW_ELEM, 32'h0000_A003, 1'b0},
    '{ROW_ELEM, 32'h0000_A004, 1'b0},
    '{ROW_ELEM, 32'h0000_A005, 1'b0},
    '{ROW_ELEM, 32'h0000_A006, 1'b0},
    '{ROW_ELEM, 32'h0000_A007, 1'b0},
    '{ROW_ELEM, 32'h0000_A008, 1'b0},
    '{ROW_ELEM, 32'hFFFF_A009, 1'b0},
    '{ROW_ELEM, 32'hFFFF_A00A, 1'b0},
    '{ROW_ELEM, 32'hFFFF_A00B, 1'b0},
    '{ROW_ELEM, 32'hFFFF_A00C, 1'b0},
    '{ROW_ELEM, 32'h5555_5555, 1'b0},
    '{ROW_ELEM, 32'hAAAA_AAAA, 1'b0},
    '{ROW_ELEM, 32'h8000_0001, 1'b0},
    '{ROW_ELEM, 32'h7FFF_FFFE, 1'b1},
    // Size lowered below the fill of an open group: all held elements
    // leave reversed on the next element.
    '{ROW_CFG,  32'd8,         1'b0},
    '{ROW_ELEM, 32'h0000_B001, 1'b0},
    '{ROW_ELEM, 32'h0000_B002, 1'b0},
    '{ROW_ELEM, 32'h0000_B003, 1'b0},
    '{ROW_CFG,  32'd2,         1'b0},
    '{ROW_ELEM, 32'h0000_B004, 1'b1}
  };

  k_group_reverse_reorder_core #(
    .MAX_GROUP(MAX_GROUP)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Zero acts as one and anything above the buffer depth acts as the depth.
  function automatic int unsigned active_size();
    if (group_size_q == '0) return 1;
    if (group_size_q > MAX_GROUP) return MAX_GROUP;
    return int'(group_size_q);
  endfunction

  // Idle gap length: mostly short, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Adds one element to the open group and queues whatever it flushes.
  task automatic reorder_elem(input logic [VALUE_W-1:0] v, input logic end_flag);
    int unsigned  n;
    bit           full;
    reorder_out_t r;
    if (open_group.size() < MAX_GROUP) open_group.push_back(v);
    n = open_group.size();
    full = (n >= active_size());
    if (full || end_flag) begin
      for (int unsigned i = 0; i < n; i++) begin
        r.value    = full ? open_group[n - 1 - i] : open_group[i];
        r.run_last = (i == n - 1);
        r.seq_end  = (i == n - 1) && end_flag;
        expected_out.push_back(r);
      end
      open_group.delete();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    if (err_count < PRINT_LIMIT)
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  // One configuration transaction, issued once all expected results have left; a group may still be open.
  task automatic write_group_size(input logic [GROUP_SIZE_W-1:0] sz);
    cfg_data  <= sz;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    group_size_q = sz;
  endtask

  // One input transaction, optionally preceded by an idle gap.
  task automatic send_elem(input logic [VALUE_W-1:0] v, input logic end_flag,
                           input bit passthrough, input bit steady);
    int unsigned  gap;
    reorder_out_t r;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 30) gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= v;
    s_axis_tlast  <= end_flag;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (passthrough) begin
      r.value    = v;
      r.run_last = 1'b1;
      r.seq_end  = end_flag;
      expected_out.push_back(r);
    end else begin
      reorder_elem(v, end_flag);
    end
  endtask

  // Waits until every expected result has left, then lets the core settle.
  task automatic settle(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  // Stimulus: directed table, then random phases under changing group sizes.
  initial begin : stimulus
    int unsigned        rand_sent;
    int unsigned        phase;
    int unsigned        sz;
    int unsigned        count;
    int unsigned        seq_left;
    int unsigned        eff;
    bit                 steady;
    logic               end_flag;
    logic [VALUE_W-1:0] v;
    group_size_q = GROUP_SIZE_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          settle(SETTLE_CYCLES);
          write_group_size(plan[i].data[GROUP_SIZE_W-1:0]);
        end
        ROW_ELEM: send_elem(plan[i].data, plan[i].last, 1'b0, 1'b0);
        default:  send_elem(plan[i].data, plan[i].last, 1'b1, 1'b0);
      endcase
    end

    rand_sent = 0;
    phase     = 0;
    seq_left  = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      settle(SETTLE_CYCLES);
      if (phase < $size(PHASE_SIZES)) sz = PHASE_SIZES[phase];
      else if ($urandom_range(0, 3) == 0) sz = $urandom_range(0, 31);
      else sz = $urandom_range(0, 6);
      write_group_size(sz[GROUP_SIZE_W-1:0]);
      eff    = active_size();
      steady = ($urandom_range(0, 3) == 0);
      count  = (eff >= 8) ? $urandom_range(16, 34) : $urandom_range(8, 20);
      // One phase keeps offering elements while the result side holds off.
      if (phase == PRESSURE_PHASE) begin
        steady = 1'b1;
        count  = 40;
        holds_asked++;
      end
      repeat (count) begin
        if (seq_left == 0) seq_left = $urandom_range(1, 3 * eff + 2);
        end_flag = (seq_left == 1);
        // Occasionally end a sequence early or miss its end.
        if ($urandom_range(0, 99) < 5) end_flag = ~end_flag;
        seq_left = end_flag ? 0 : seq_left - 1;
        v = $urandom();
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = 32'h0000_0000;
            default: v = 32'hFFFF_FFFF;
          endcase
        end
        send_elem(v, end_flag, 1'b0, steady);
        rand_sent++;
      end
      phase++;
    end

    settle(TAIL_CYCLES);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side back-pressure: random stalls, calm stretches, one long hold.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned calm_left;
    int          holds_served;
    stall_left   = 0;
    calm_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_served) begin
        holds_served = holds_asked;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(20, 60);
        else if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // Compare each result transaction against the oldest expected result.
  always @(posedge clk) begin : result_check
    reorder_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_out.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, '0);
      end else begin
        want = expected_out.pop_front();
        if (m_axis_tdata !== want.value)
          report_mismatch("out_value", m_axis_tdata, want.value);
        if (m_axis_tuser[0] !== want.run_last)
          report_mismatch("run_last", {31'd0, m_axis_tuser[0]}, {31'd0, want.run_last});
        if (m_axis_tlast !== want.seq_end)
          report_mismatch("out_seq_end", {31'd0, m_axis_tlast}, {31'd0, want.seq_end});
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
